// ===== src/tcma_pkg.sv =====
// Shared types and constants for the two-channel moving average.
// Depends on nothing; every other file imports it.
`default_nettype none

package tcma_pkg;

   localparam int WINDOW_SAMPLES = 10;

   localparam int TEMP_W = 11;
   localparam int HUM_W  = 10;
   localparam int HELD_W = 4;

   localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
   localparam int IDX_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

   localparam int TSUM_W = TEMP_W + CNT_W;
   localparam int HSUM_W = HUM_W + CNT_W;
   // 2*|sum| + n fits in one bit over the humidity sum
   localparam int DVD_W  = HSUM_W + 1;
   localparam int DVS_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(DVD_W + 1);

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_TSTART,
      ST_TWAIT,
      ST_HSTART,
      ST_HWAIT,
      ST_DONE
   } tcma_state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } tcma_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } tcma_div_rsp_type;

endpackage

`default_nettype wire

// ===== src/tcma_window.sv =====
// Sample window: two ring stores, write position and full flag.
// Registered read port. Depends on tcma_pkg.
`default_nettype none

module tcma_window
   import tcma_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic signed [TEMP_W-1:0] wr_temp,
   input  wire logic [HUM_W-1:0]         wr_hum,
   input  wire logic [IDX_W-1:0]         rd_idx,
   output logic signed [TEMP_W-1:0]      rd_temp,
   output logic [HUM_W-1:0]              rd_hum,
   output logic [CNT_W-1:0]              held_count
);

   logic signed [TEMP_W-1:0] temp_mem [WINDOW_SAMPLES];
   logic [HUM_W-1:0]         hum_mem  [WINDOW_SAMPLES];

   logic [IDX_W-1:0] write_pos_ff, write_pos_in;
   logic             window_full_ff, window_full_in;
   logic             wrap;

   assign wrap = (write_pos_ff == IDX_W'(WINDOW_SAMPLES - 1));

   always_comb begin
      write_pos_in   = write_pos_ff;
      window_full_in = window_full_ff;
      if (wr_en) begin
         if (wrap) begin
            write_pos_in   = '0;
            window_full_in = 1'b1;
         end else begin
            write_pos_in = write_pos_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff   <= '0;
         window_full_ff <= 1'b0;
      end else begin
         write_pos_ff   <= write_pos_in;
         window_full_ff <= window_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         temp_mem[write_pos_ff] <= wr_temp;
         hum_mem[write_pos_ff]  <= wr_hum;
      end
      rd_temp <= temp_mem[rd_idx];
      rd_hum  <= hum_mem[rd_idx];
   end

   assign held_count = window_full_ff ? CNT_W'(WINDOW_SAMPLES) : CNT_W'(write_pos_ff);

endmodule

`default_nettype wire

// ===== src/tcma_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Used once per channel for the rounded mean. Depends on tcma_pkg.
`default_nettype none

module tcma_divider
   import tcma_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tcma_div_req_type req,
   output tcma_div_rsp_type      rsp
);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/two_channel_moving_average.sv =====
// Top level: two-channel moving average over a window of readings.
// Instantiates tcma_window and tcma_divider; depends on tcma_pkg.
//
// channel  dir  tdata bits (low up)                         tuser bits
// req      in   temperature_tenths[10:0] humidity[20:11]    [0] reading_valid
// rsp      out  avg_temp[10:0] avg_hum[20:11] held[24:21]   [0] average_valid
//                                                           [1] sample_accepted
//
// An item passes from accept through the sum state, a start and a wait state
// for each channel's divide, and the done state to the result. The window sum
// walks the store one entry a cycle over the N samples held (0..WINDOW_SAMPLES);
// the shared divider works through the dividend bit by bit for each channel. An empty
// window skips both divides. The next item can be taken once the result loads.
// req_tready is high only while the sequencer is idle; the result sits in an
// output register, so a new item is taken while rsp is stalled.
// Synchronous active-high reset clears position, full flag and control state.
`default_nettype none

module two_channel_moving_average
   import tcma_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [10:0] temperature_tenths, [20:11] humidity_tenths, [23:21] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] reading_valid
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [10:0] average_temperature_tenths, [20:11] average_humidity_tenths,
   // [24:21] samples_held, [31:25] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] average_valid, [1] sample_accepted
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   tcma_state_type state_ff, state_in;

   // input fields
   logic signed [TEMP_W-1:0] in_temp;
   logic [HUM_W-1:0]         in_hum;
   logic                     in_valid;
   logic                     accept;

   assign in_temp  = req_tdata[TEMP_W-1:0];
   assign in_hum   = req_tdata[TEMP_W+HUM_W-1:TEMP_W];
   assign in_valid = req_tuser[0];
   assign accept   = req_tvalid && req_tready;

   // window
   logic [IDX_W-1:0]         rd_idx;
   logic signed [TEMP_W-1:0] rd_temp;
   logic [HUM_W-1:0]         rd_hum;
   logic [CNT_W-1:0]         held_count;

   tcma_window u_window (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && in_valid),
      .wr_temp    (in_temp),
      .wr_hum     (in_hum),
      .rd_idx     (rd_idx),
      .rd_temp    (rd_temp),
      .rd_hum     (rd_hum),
      .held_count (held_count)
   );

   // divider
   tcma_div_req_type div_req;
   tcma_div_rsp_type div_rsp;

   tcma_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // working registers
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [TSUM_W-1:0] tsum_ff, tsum_in;
   logic [HSUM_W-1:0]        hsum_ff, hsum_in;
   logic [TEMP_W-1:0]        tavg_ff, tavg_in;
   logic [HUM_W-1:0]         havg_ff, havg_in;
   logic                     stored_ff, stored_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0]        out_temp_ff, out_temp_in;
   logic [HUM_W-1:0]         out_hum_ff, out_hum_in;
   logic [HELD_W-1:0]        out_held_ff, out_held_in;
   logic                     out_avgv_ff, out_avgv_in;
   logic                     out_acc_ff, out_acc_in;

   logic                     out_free;
   logic                     sum_last;
   logic                     tsum_neg;
   logic [TSUM_W-1:0]        tsum_mag;
   logic [TEMP_W-1:0]        tq;

   assign out_free = !out_valid_ff || rsp_tready;
   assign sum_last = (idx_ff == held_count);
   assign tsum_neg = tsum_ff[TSUM_W-1];
   assign tsum_mag = tsum_neg ? TSUM_W'(-tsum_ff) : TSUM_W'(tsum_ff);
   assign tq       = div_rsp.quotient[TEMP_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SUM;
         ST_SUM: begin
            if (sum_last) state_in = (held_count == '0) ? ST_DONE : ST_TSTART;
         end
         ST_TSTART: state_in = ST_TWAIT;
         ST_TWAIT:  if (div_rsp.done) state_in = ST_HSTART;
         ST_HSTART: state_in = ST_HWAIT;
         ST_HWAIT:  if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rd_idx     = (idx_ff < held_count) ? idx_ff[IDX_W-1:0] : '0;

      div_req.start    = 1'b0;
      div_req.divisor  = {held_count, 1'b0};
      div_req.dividend = DVD_W'({tsum_mag, 1'b0}) + DVD_W'(held_count);
      if (state_ff == ST_HSTART) begin
         div_req.dividend = DVD_W'({hsum_ff, 1'b0}) + DVD_W'(held_count);
      end
      if (state_ff == ST_TSTART || state_ff == ST_HSTART) begin
         div_req.start = 1'b1;
      end
   end

   // datapath
   always_comb begin
      idx_in    = idx_ff;
      tsum_in   = tsum_ff;
      hsum_in   = hsum_ff;
      tavg_in   = tavg_ff;
      havg_in   = havg_ff;
      stored_in = stored_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_temp_in  = out_temp_ff;
      out_hum_in   = out_hum_ff;
      out_held_in  = out_held_ff;
      out_avgv_in  = out_avgv_ff;
      out_acc_in   = out_acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = '0;
               tsum_in   = '0;
               hsum_in   = '0;
               tavg_in   = '0;
               havg_in   = '0;
               stored_in = in_valid;
            end
         end
         ST_SUM: begin
            // data read at idx-1 arrives now
            if (idx_ff != '0) begin
               tsum_in = tsum_ff + {{(TSUM_W-TEMP_W){rd_temp[TEMP_W-1]}}, rd_temp};
               hsum_in = hsum_ff + HSUM_W'(rd_hum);
            end
            if (!sum_last) idx_in = idx_ff + CNT_W'(1);
         end
         ST_TWAIT: begin
            if (div_rsp.done) tavg_in = tsum_neg ? TEMP_W'(-tq) : tq;
         end
         ST_HWAIT: begin
            if (div_rsp.done) havg_in = div_rsp.quotient[HUM_W-1:0];
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_temp_in  = tavg_ff;
               out_hum_in   = havg_ff;
               out_held_in  = HELD_W'(held_count);
               out_avgv_in  = (held_count != '0);
               out_acc_in   = stored_ff;
            end
         end
         ST_TSTART, ST_HSTART: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      tsum_ff     <= tsum_in;
      hsum_ff     <= hsum_in;
      tavg_ff     <= tavg_in;
      havg_ff     <= havg_in;
      stored_ff   <= stored_in;
      out_temp_ff <= out_temp_in;
      out_hum_ff  <= out_hum_in;
      out_held_ff <= out_held_in;
      out_avgv_ff <= out_avgv_in;
      out_acc_ff  <= out_acc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-TEMP_W-HUM_W-HELD_W)'(0),
                        out_held_ff, out_hum_ff, out_temp_ff};
   assign rsp_tuser  = {out_acc_ff, out_avgv_ff};

endmodule

`default_nettype wire

// ===== src/tcma_checker.sv =====
// Port-level checks for two_channel_moving_average, bound to the top level.
// Depends on tcma_pkg.
`default_nettype none

module tcma_checker
   import tcma_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item shown after reset");

   // the sequencer is busy after taking an item, so items are never taken back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken in back-to-back cycles");

   // empty window gives zero averages and a zero count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[24:0] == 25'd0)
      else $error("averages nonzero with empty window");

   // a stored reading means at least one sample is held
   a_accept_implies_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("stored sample but average not valid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind two_channel_moving_average tcma_checker u_tcma_checker (.*);

`default_nettype wire
